FILE: rtl/bfcq15_pkg.sv
// shared types and constants for the q15 block fir filter
`timescale 1ns / 1ps

package bfcq15_pkg;

    // default filter geometry
    localparam int TAPS_DEF  = 513;
    localparam int BLOCK_DEF = 512;

    // fixed field widths
    localparam int TAP_IDX_W = 10;
    localparam int SAMPLE_W  = 16;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // item action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_COEF   = 1'b1;

    // register index codes (byte address bit 2)
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_PASS   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ABS,
        ST_ROUND,
        ST_PREAD,
        ST_PWAIT,
        ST_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic coef_wr;
        logic smp_wr;
        logic mac_issue;
        logic pass_cap;
        logic abs_step;
        logic round_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic mac_last;
        logic pipe_empty;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/bfcq15_dp.sv
// datapath: tap and history memories, serial mac, rounding and output register
`timescale 1ns / 1ps

module bfcq15_dp
    import bfcq15_pkg::*;
#(
    parameter int TAPS  = TAPS_DEF,
    parameter int BLOCK = BLOCK_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic [TAP_IDX_W-1:0]       i_tap_index,
    input  logic signed [SAMPLE_W-1:0] i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out
);

    localparam int HIST  = BLOCK + TAPS;
    localparam int KW    = $clog2(TAPS);
    localparam int PW    = $clog2(HIST);
    localparam int FW    = $clog2(HIST + 1);
    localparam int VW    = $clog2(TAPS + 1);
    localparam int ACC_W = 32 + $clog2(TAPS);

    // memories
    logic signed [SAMPLE_W-1:0] r_tap_mem  [TAPS];
    logic signed [SAMPLE_W-1:0] r_hist_mem [HIST];
    logic signed [SAMPLE_W-1:0] r_tap_q;
    logic signed [SAMPLE_W-1:0] r_hist_q;

    // control registers
    logic [KW-1:0] r_k;
    logic [PW-1:0] r_pos;
    logic [FW-1:0] r_fill;
    logic [VW-1:0] r_vleft;
    logic [PW-1:0] r_rd_ptr;
    logic          r_b_go;
    logic          r_b_vld;
    logic          r_c_go;
    logic          r_out_valid;

    // arithmetic registers
    logic signed [31:0]          r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic [ACC_W-1:0]            r_mag;
    logic                        r_neg;
    logic signed [SAMPLE_W-1:0]  r_res;
    logic signed [SAMPLE_W-1:0]  r_out_data;

    logic [31:0]                w_tap_ext;
    logic                       w_tap_ok;
    logic                       w_tap_we;
    logic [KW-1:0]              w_tap_waddr;
    logic signed [SAMPLE_W-1:0] w_tap_wdata;
    logic [KW-1:0]              w_k_next;
    logic [PW-1:0]              w_pos_next;
    logic [PW-1:0]              w_rd_start;
    logic [FW-1:0]              w_fill_next;
    logic [VW-1:0]              w_vleft_start;
    logic signed [31:0]         w_prod;
    logic [ACC_W-1:0]           w_rnd;
    logic [ACC_W-1:0]           w_q;
    logic signed [SAMPLE_W-1:0] w_rounded;

    // tap index range check and tap write port
    always_comb begin
        w_tap_ext   = 32'(i_tap_index);
        w_tap_ok    = w_tap_ext < 32'(TAPS);
        w_tap_we    = i_cmd.clr_step || (i_cmd.coef_wr && w_tap_ok);
        w_tap_waddr = i_cmd.clr_step ? r_k : w_tap_ext[KW-1:0];
        w_tap_wdata = i_cmd.clr_step ? '0 : i_value;
    end

    // tap counter wraps at the last tap
    assign w_k_next = (r_k == KW'(TAPS - 1)) ? '0 : r_k + 1'b1;

    // history pointer, read start at age BLOCK and valid tap count
    always_comb begin
        w_pos_next  = (r_pos == PW'(HIST - 1)) ? '0 : r_pos + 1'b1;
        w_rd_start  = (w_pos_next >= PW'(BLOCK)) ? w_pos_next - PW'(BLOCK)
                                                 : w_pos_next + PW'(TAPS);
        w_fill_next = (r_fill == FW'(HIST)) ? r_fill : r_fill + 1'b1;
        w_vleft_start = (w_fill_next > FW'(BLOCK)) ? VW'(w_fill_next - FW'(BLOCK)) : '0;
    end

    // tap memory
    always_ff @(posedge i_clk) begin
        if (w_tap_we) begin
            r_tap_mem[w_tap_waddr] <= w_tap_wdata;
        end
        r_tap_q <= r_tap_mem[r_k];
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_wr) begin
            r_hist_mem[w_pos_next] <= i_value;
        end
        r_hist_q <= r_hist_mem[r_rd_ptr];
    end

    // tap counter, history pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_pos   <= '0;
            r_fill  <= '0;
            r_vleft <= '0;
        end else begin
            if (i_cmd.clr_step || i_cmd.mac_issue) begin
                r_k <= w_k_next;
            end else if (i_cmd.smp_wr) begin
                r_k <= '0;
            end
            if (i_cmd.coef_wr && w_tap_ok) begin
                r_pos  <= '0;
                r_fill <= '0;
            end else if (i_cmd.smp_wr) begin
                r_pos  <= w_pos_next;
                r_fill <= w_fill_next;
            end
            if (i_cmd.smp_wr) begin
                r_vleft <= w_vleft_start;
            end else if (i_cmd.mac_issue && (r_vleft != '0)) begin
                r_vleft <= r_vleft - 1'b1;
            end
        end
    end

    // history read pointer walks toward older samples
    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_wr) begin
            r_rd_ptr <= w_rd_start;
        end else if (i_cmd.mac_issue) begin
            r_rd_ptr <= (r_rd_ptr == '0) ? PW'(HIST - 1) : r_rd_ptr - 1'b1;
        end
    end

    // mac pipeline flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_go <= 1'b0;
            r_c_go <= 1'b0;
        end else begin
            r_b_go <= i_cmd.mac_issue;
            r_c_go <= r_b_go;
        end
    end

    // signed 16 by 16 product
    assign w_prod = r_hist_q * r_tap_q;

    // multiply and accumulate; unwritten history reads as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_issue) begin
            r_b_vld <= (r_vleft != '0);
        end
        r_prod <= r_b_vld ? w_prod : '0;
        if (i_cmd.smp_wr) begin
            r_acc <= '0;
        end else if (r_c_go) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round half away from zero and saturate
    always_comb begin
        w_rnd = r_mag + ACC_W'(16384);
        w_q   = w_rnd >> 15;
        if (!r_neg) begin
            w_rounded = (w_q > ACC_W'(32767)) ? 16'sh7fff : w_q[SAMPLE_W-1:0];
        end else begin
            w_rounded = (w_q > ACC_W'(32768)) ? 16'sh8000
                                              : SAMPLE_W'(16'd0 - w_q[SAMPLE_W-1:0]);
        end
    end

    // magnitude and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.abs_step) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        end
        if (i_cmd.round_step) begin
            r_res <= w_rounded;
        end else if (i_cmd.pass_cap) begin
            r_res <= r_b_vld ? r_hist_q : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_res;
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.clr_last   = (r_k == KW'(TAPS - 1));
        o_stat.mac_last   = (r_k == KW'(TAPS - 1));
        o_stat.pipe_empty = !r_b_go && !r_c_go;
        o_stat.out_free   = !r_out_valid || !i_stall;
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule

FILE: rtl/bfcq15_ctrl.sv
// controller state machine sequencing clear, mac, rounding, pass-through and output
`timescale 1ns / 1ps

module bfcq15_ctrl
    import bfcq15_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_action,
    input  logic     i_enable,
    input  logic     i_pass,
    input  t_dp_stat i_stat,
    output logic     o_stall,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_smp;

    assign w_accept = i_valid && (r_state == ST_IDLE);
    assign w_smp    = w_accept && (i_action == ACT_SAMPLE) && i_enable;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_smp) n_state = i_pass ? ST_PREAD : ST_MAC;
            end
            ST_MAC: begin
                if (i_stat.mac_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_stat.pipe_empty) n_state = ST_ABS;
            end
            ST_ABS:   n_state = ST_ROUND;
            ST_ROUND: n_state = ST_OUT;
            ST_PREAD: n_state = ST_PWAIT;
            ST_PWAIT: n_state = ST_OUT;
            ST_OUT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_cmd.coef_wr = w_accept && (i_action == ACT_COEF);
                o_cmd.smp_wr  = w_smp;
            end
            ST_MAC:   o_cmd.mac_issue  = 1'b1;
            ST_DRAIN: ;
            ST_ABS:   o_cmd.abs_step   = 1'b1;
            ST_ROUND: o_cmd.round_step = 1'b1;
            ST_PREAD: o_cmd.mac_issue  = 1'b1;
            ST_PWAIT: o_cmd.pass_cap   = 1'b1;
            ST_OUT:   o_cmd.out_load   = i_stat.out_free;
            default:  ;
        endcase
    end

endmodule

FILE: rtl/block_fir_convolution_q15.sv
// top level: q15 block fir filter with register port, controller and datapath
// Q15 FIR filter with TAPS taps and one block (BLOCK samples) of delay: each
// enabled audio sample gives one result, the rounded (half away from zero) and
// saturated sum of h[k]*x[n-BLOCK-k], or x[n-BLOCK] in pass-through mode.
// A filtered sample is computed by the single multiply-accumulate that reads
// one tap and one history word per cycle. A coefficient write with an in-range
// index stores the tap and empties the history. After reset the tap memory is
// cleared while o_stall stays high. A finished result waits in the output
// register while the next item is taken.
`timescale 1ns / 1ps

module block_fir_convolution_q15
    import bfcq15_pkg::*;
#(
    parameter int TAPS  = TAPS_DEF,
    parameter int BLOCK = BLOCK_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_action,
    input  logic [TAP_IDX_W-1:0]       i_tap_index,
    input  logic signed [SAMPLE_W-1:0] i_value,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    logic     r_enable;
    logic     r_pass;
    logic     w_reg_idx;
    logic     w_wr;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];
    assign w_wr      = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_pass   <= 1'b0;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_ENABLE: r_enable <= pwdata[0];
                REG_PASS:   r_pass   <= pwdata[0];
                default:    ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (w_reg_idx)
            REG_ENABLE: prdata = DATA_W'(r_enable);
            REG_PASS:   prdata = DATA_W'(r_pass);
            default:    prdata = '0;
        endcase
    end

    bfcq15_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_enable (r_enable),
        .i_pass   (r_pass),
        .i_stat   (w_stat),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    bfcq15_dp #(
        .TAPS  (TAPS),
        .BLOCK (BLOCK)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_tap_index  (i_tap_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_out (o_sample_out)
    );

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the q15 block fir filter: directed and random transactions
`timescale 1ns / 1ps

module testbench;
    import bfcq15_pkg::*;

    localparam int HIST_LEN    = BLOCK_DEF + TAPS_DEF;
    localparam int TAIL_CYCLES = TAPS_DEF + 80;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic                       i_action;
    logic [TAP_IDX_W-1:0]       i_tap_index;
    logic signed [SAMPLE_W-1:0] i_value;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    // filter state as the testbench sees it
    logic signed [SAMPLE_W-1:0] tap_mem [TAPS_DEF];
    logic signed [SAMPLE_W-1:0] sample_hist [HIST_LEN];
    int unsigned                hist_wr;
    int unsigned                blk_phase;
    logic                       cfg_enable;
    logic                       cfg_pass;
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] head_sample;

    int errors        = 0;
    int items_sent    = 0;
    int send_idle_pct = 31;
    int recv_idle_pct = 59;
    int hold_req      = 0;
    int hold_left     = 0;

    block_fir_convolution_q15 u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_tap_index  (i_tap_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_out (o_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // q30 accumulator to q15, ties away from zero, saturated
    function automatic logic signed [SAMPLE_W-1:0] round_q30(input longint acc);
        longint q;
        if (acc >= 0) q = (acc + 16384) >>> 15;
        else q = -((-acc + 16384) >>> 15);
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    // sample that arrived age samples before the newest one
    function automatic logic signed [SAMPLE_W-1:0] aged_sample(input int unsigned age);
        return sample_hist[(hist_wr + HIST_LEN - age) % HIST_LEN];
    endfunction

    // random q15 value, with a share of corner values
    function automatic logic signed [SAMPLE_W-1:0] pick_q15(input int special_pct);
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(0, 99) < special_pct) begin
            case ($urandom_range(0, 6))
                0: r = 32'h8000;
                1: r = 32'h7fff;
                2: r = 32'h4000;
                3: r = 32'hc000;
                4: r = 32'h0000;
                5: r = 32'h0001;
                default: r = 32'hffff;
            endcase
        end
        return r[SAMPLE_W-1:0];
    endfunction

    // update the filter state for one accepted transaction, queue its output
    task automatic predict_fir(input logic act, input logic [TAP_IDX_W-1:0] idx,
                               input logic signed [SAMPLE_W-1:0] val);
        longint acc;
        if (act == ACT_COEF) begin
            // out-of-range tap index leaves everything alone
            if (idx < TAPS_DEF) begin
                tap_mem[idx] = val;
                foreach (sample_hist[i]) sample_hist[i] = '0;
                hist_wr   = 0;
                blk_phase = 0;
            end
        end else if (cfg_enable) begin
            hist_wr              = (hist_wr + 1) % HIST_LEN;
            sample_hist[hist_wr] = val;
            blk_phase            = (blk_phase + 1) % BLOCK_DEF;
            if (cfg_pass) begin
                expected_samples.push_back(aged_sample(BLOCK_DEF));
            end else begin
                acc = 0;
                for (int k = 0; k < TAPS_DEF; k++)
                    acc += longint'(tap_mem[k]) * longint'(aged_sample(BLOCK_DEF + k));
                expected_samples.push_back(round_q30(acc));
            end
        end
    endtask

    // offer one transaction and hold it until accepted
    task automatic send_item(input logic act, input logic [TAP_IDX_W-1:0] idx,
                             input logic signed [SAMPLE_W-1:0] val);
        int gap;
        if (items_sent < 550) begin
            send_idle_pct = 31;
            recv_idle_pct = 59;
        end else if (items_sent < 1100) begin
            send_idle_pct = 59;
            recv_idle_pct = 31;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_tap_index <= idx;
        i_value     <= val;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        predict_fir(act, idx, val);
        items_sent++;
    endtask

    // stop offering and wait until every queued output has come back
    task automatic drain_results(input int extra);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_samples.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(input logic reg_id, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (reg_id == REG_ENABLE) cfg_enable = data[0];
        else cfg_pass = data[0];
    endtask

    task automatic configure(input logic en, input logic pass);
        drain_results(8);
        write_reg(REG_ENABLE, {{(DATA_W-1){1'b0}}, en});
        write_reg(REG_PASS, {{(DATA_W-1){1'b0}}, pass});
    endtask

    // reset state: samples dropped, coefficient writes taken, bad indexes ignored
    task automatic test_disabled_and_coef_writes;
        send_item(ACT_SAMPLE, 10'd0, 16'h8000);
        send_item(ACT_SAMPLE, 10'h3ff, 16'h7fff);
        send_item(ACT_COEF, 10'd0, 16'h7fff);
        send_item(ACT_COEF, 10'd512, 16'h8000);
        send_item(ACT_COEF, 10'd513, 16'h0001);
        send_item(ACT_COEF, 10'h3ff, 16'hffff);
    endtask

    // history not yet filled counts as zero, in both modes
    task automatic test_young_history;
        configure(1'b1, 1'b1);
        send_item(ACT_SAMPLE, 10'h155, 16'h8000);
        send_item(ACT_SAMPLE, 10'h2aa, 16'h7fff);
        send_item(ACT_SAMPLE, 10'd0, 16'h0000);
        send_item(ACT_SAMPLE, 10'h3ff, 16'hffff);
        configure(1'b1, 1'b0);
        send_item(ACT_SAMPLE, 10'd7, 16'h7fff);
        send_item(ACT_SAMPLE, 10'd9, 16'h8000);
        send_item(ACT_SAMPLE, 10'd1, 16'h5555);
    endtask

    // single +-1 tap: output is an old sample scaled, exposing ties and sign
    task automatic test_rounding_single_tap;
        logic [TAP_IDX_W-1:0] k_idx;
        int                   n_prime;
        k_idx   = TAP_IDX_W'($urandom_range(0, 31));
        n_prime = BLOCK_DEF + int'(k_idx) + $urandom_range(0, 4);
        send_item(ACT_COEF, 10'd0, 16'h0000);
        send_item(ACT_COEF, 10'd512, 16'h0000);
        send_item(ACT_COEF, k_idx, $urandom_range(0, 1) ? 16'h0001 : 16'hffff);
        // fill the history through the pass-through path
        configure(1'b1, 1'b1);
        repeat (n_prime) send_item(ACT_SAMPLE, TAP_IDX_W'($urandom), pick_q15(60));
        configure(1'b1, 1'b0);
        repeat (15) send_item(ACT_SAMPLE, TAP_IDX_W'($urandom), pick_q15(60));
        // disabled stretch: dropped samples leave the history alone
        configure(1'b0, 1'b0);
        repeat (3) send_item(ACT_SAMPLE, TAP_IDX_W'($urandom), pick_q15(30));
        configure(1'b1, 1'b0);
        repeat (15) send_item(ACT_SAMPLE, TAP_IDX_W'($urandom), pick_q15(60));
    endtask

    // many taps over a history filled past the first taps, long receiver hold-off
    task automatic test_full_history_backpressure;
        int n_prime;
        n_prime = BLOCK_DEF + 44 + $urandom_range(0, 8);
        // coefficient writes right behind filtered samples still in flight
        send_item(ACT_COEF, 10'd0, $urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
        send_item(ACT_COEF, 10'd512, pick_q15(60));
        repeat (6) send_item(ACT_COEF, TAP_IDX_W'($urandom_range(1, 40)), pick_q15(50));
        repeat (2) send_item(ACT_COEF, TAP_IDX_W'($urandom_range(TAPS_DEF, 1023)),
                             pick_q15(30));
        configure(1'b1, 1'b1);
        for (int i = 0; i < n_prime; i++) begin
            if (i == 200) hold_req <= 300;
            send_item(ACT_SAMPLE, TAP_IDX_W'($urandom), pick_q15(40));
        end
        configure(1'b1, 1'b0);
        repeat (20) send_item(ACT_SAMPLE, TAP_IDX_W'($urandom), pick_q15(40));
        // ignored write in mid stream keeps the history
        send_item(ACT_COEF, TAP_IDX_W'($urandom_range(TAPS_DEF, 1023)), pick_q15(30));
        repeat (20) send_item(ACT_SAMPLE, TAP_IDX_W'($urandom), pick_q15(40));
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left <= hold_req - 1;
            hold_req  <= 0;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // compare each output transaction with the oldest expected sample
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample_out, expected none, actual %0d",
                         $time, o_sample_out);
                errors++;
            end else begin
                head_sample = expected_samples.pop_front();
                if (o_sample_out !== head_sample) begin
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, head_sample, o_sample_out);
                    errors++;
                end
            end
        end
    end

    // test sequence
    initial begin
        foreach (tap_mem[i]) tap_mem[i] = '0;
        foreach (sample_hist[i]) sample_hist[i] = '0;
        hist_wr     = 0;
        blk_phase   = 0;
        cfg_enable  = 1'b0;
        cfg_pass    = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_action    <= ACT_SAMPLE;
        i_tap_index <= '0;
        i_value     <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // tap memory clearing pass after reset
        do @(posedge i_clk); while (o_stall !== 1'b0);
        test_disabled_and_coef_writes();
        test_young_history();
        test_rounding_single_tap();
        test_full_history_backpressure();
        drain_results(TAIL_CYCLES);
        if (errors == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end

    // run limit
    initial begin
        #30000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
